/* hdl/knng_pkg.sv */
// shared constants, types and codes of the k-nearest-neighbor graph block
`default_nettype none
package knng_pkg;

    // sizes of the point store and the neighbor list
    localparam int MAX_POINTS    = 256;
    localparam int MAX_DIMS      = 16;
    localparam int MAX_NEIGHBORS = 64;
    localparam int COORD_BITS    = 16;

    localparam int PIDX_W   = $clog2(MAX_POINTS);
    localparam int DIDX_W   = $clog2(MAX_DIMS);
    localparam int ADDR_W   = PIDX_W + DIDX_W;
    localparam int DIST_W   = 36;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int CHAIN_LEN = MAX_NEIGHBORS + 1;

    // register widths and indexes
    localparam int NC_W  = 7;
    localparam int PC_W  = 9;
    localparam int DC_W  = 5;
    localparam int CFG_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION_COUNT = 2'd2;
    localparam logic [NC_W-1:0] NC_RESET = 7'd4;
    localparam logic [PC_W-1:0] PC_RESET = 9'd256;
    localparam logic [DC_W-1:0] DC_RESET = 5'd2;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // one entry of the sorted neighbor chain
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sq_dist;
        logic [PIDX_W-1:0] idx;
    } item_t;

    // operation applied to every cell in the same cycle
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* hdl/knng_store.sv */
// coordinate store with one write port and two registered read ports
`default_nettype none
module knng_store (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [knng_pkg::ADDR_W-1:0]      waddr,
    input  wire logic [knng_pkg::COORD_BITS-1:0]  wdata,
    input  wire logic [knng_pkg::ADDR_W-1:0]      raddr_a,
    input  wire logic [knng_pkg::ADDR_W-1:0]      raddr_b,
    output logic      [knng_pkg::COORD_BITS-1:0]  rdata_a,
    output logic      [knng_pkg::COORD_BITS-1:0]  rdata_b
);
    logic [knng_pkg::COORD_BITS-1:0] mem [0:knng_pkg::MAX_POINTS*knng_pkg::MAX_DIMS-1];

    // write and read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

/* hdl/knng_cell.sv */
// one cell of the sorted neighbor chain: insert, rotate or clear
`default_nettype none
module knng_cell (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire knng_pkg::cell_ctrl_t   ctrl,
    input  wire knng_pkg::item_t        new_item,
    input  wire knng_pkg::item_t        left_item,
    input  wire knng_pkg::item_t        right_item,
    output knng_pkg::item_t             own_item
);
    knng_pkg::item_t own_reg;
    knng_pkg::item_t own_next;
    logic new_lt_own;
    logic new_lt_left;

    // new items arrive in index order, so a tie stays behind the held entry
    assign new_lt_own  = !own_reg.valid || (new_item.sq_dist < own_reg.sq_dist);
    assign new_lt_left = !left_item.valid || (new_item.sq_dist < left_item.sq_dist);

    always_comb begin
        own_next = own_reg;
        if (ctrl.insert) begin
            if (new_lt_left) begin
                own_next = left_item;
            end else if (new_lt_own) begin
                own_next = new_item;
            end
        end else if (ctrl.rotate) begin
            own_next = right_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg.valid <= 1'b0;
        end else if (ctrl.clear) begin
            own_reg.valid <= 1'b0;
        end else begin
            own_reg.valid <= own_next.valid;
        end
        own_reg.sq_dist <= own_next.sq_dist;
        own_reg.idx     <= own_next.idx;
    end

    assign own_item = own_reg;
endmodule
`default_nettype wire

/* hdl/knng_chain.sv */
// row of sorted cells holding the nearest candidates of the current query
`default_nettype none
module knng_chain (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire knng_pkg::cell_ctrl_t   ctrl,
    input  wire knng_pkg::item_t        new_item,
    output knng_pkg::item_t             head,
    output knng_pkg::item_t             second,
    output knng_pkg::item_t             tail
);
    knng_pkg::item_t cell_q [0:knng_pkg::CHAIN_LEN-1];
    knng_pkg::item_t left_q [0:knng_pkg::CHAIN_LEN-1];
    knng_pkg::item_t right_q [0:knng_pkg::CHAIN_LEN-1];

    // neighbor wiring, the chain closes into a ring for rotation
    always_comb begin
        left_q[0] = '{valid: 1'b1, sq_dist: '0, idx: '0};
        for (int i = 1; i < knng_pkg::CHAIN_LEN; i++) begin
            left_q[i] = cell_q[i-1];
        end
        for (int i = 0; i < knng_pkg::CHAIN_LEN - 1; i++) begin
            right_q[i] = cell_q[i+1];
        end
        right_q[knng_pkg::CHAIN_LEN-1] = cell_q[0];
    end

    for (genvar g = 0; g < knng_pkg::CHAIN_LEN; g++) begin : g_cell
        knng_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_item   (new_item),
            .left_item  (left_q[g]),
            .right_item (right_q[g]),
            .own_item   (cell_q[g])
        );
    end

    assign head   = cell_q[0];
    assign second = cell_q[1];
    assign tail   = cell_q[knng_pkg::CHAIN_LEN-1];
endmodule
`default_nettype wire

/* hdl/knn_graph_from_points_core.sv */
// top level: point loading, distance walk, neighbor chain and result emission
//
// Input stream (s_): one transaction is a coordinate load (s_tuser = 0) or a
// neighbor query (s_tuser = 1). A load writes one coordinate into the point
// store and gives no result. A query walks the taking-part points one
// coordinate per cycle through a multiply-accumulate pipeline and lets it
// drain, then makes a full pass around the neighbor chain to find the cut
// distance, sets the overflow flag and emits the results. An empty answer gives
// one result at once; a duplicate ends the walk early and gives one result.
// The walk rate is set by the two read ports of the point store.
// Output stream (m_): one transaction per reported neighbor, m_tlast on the
// final one of a query. The result sits in an output register; while the
// receiver stalls, the emission waits and new loads are still taken when idle.
// Config port: cfg_wr_en writes cfg_wdata into register cfg_index at once.
// Reset (aresetn low, synchronous) empties the pipeline and the chain and sets
// neighbor_count 4, point_count 256, dimension_count 2; the store is not cleared.
`default_nettype none
module knn_graph_from_points_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // point_index[7:0], dim_index[11:8], coord_value[27:12], zero fill
    input  wire logic [knng_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[0]
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // neighbor_index[7:0], sq_distance[43:8], zero fill
    output logic      [knng_pkg::M_TDATA_W-1:0]    m_tdata,
    // is_duplicate[0], overflow[1], empty_res[2]
    output logic      [knng_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [knng_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [knng_pkg::CFG_W-1:0]        cfg_wdata
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK, ST_DRAIN, ST_ROT, ST_FLAG, ST_EMIT, ST_ONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [knng_pkg::NC_W-1:0] nc_reg;
    logic [knng_pkg::PC_W-1:0] pc_reg;
    logic [knng_pkg::DC_W-1:0] dc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg <= knng_pkg::NC_RESET;
            pc_reg <= knng_pkg::PC_RESET;
            dc_reg <= knng_pkg::DC_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                knng_pkg::CFG_NEIGHBOR_COUNT:  nc_reg <= cfg_wdata[knng_pkg::NC_W-1:0];
                knng_pkg::CFG_POINT_COUNT:     pc_reg <= cfg_wdata[knng_pkg::PC_W-1:0];
                knng_pkg::CFG_DIMENSION_COUNT: dc_reg <= cfg_wdata[knng_pkg::DC_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [knng_pkg::PIDX_W-1:0]     in_pi;
    logic [knng_pkg::DIDX_W-1:0]     in_di;
    logic [knng_pkg::COORD_BITS-1:0] in_coord;
    logic                            s_fire;

    assign in_pi    = s_tdata[7:0];
    assign in_di    = s_tdata[11:8];
    assign in_coord = s_tdata[27:12];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // effective query settings
    logic [knng_pkg::PC_W-1:0] n_eff;
    logic [knng_pkg::DC_W-1:0] d_eff;
    logic [knng_pkg::NC_W-1:0] k_eff;
    logic                      q_empty;

    assign n_eff = (pc_reg > knng_pkg::PC_W'(knng_pkg::MAX_POINTS))
                 ? knng_pkg::PC_W'(knng_pkg::MAX_POINTS) : pc_reg;
    assign d_eff = (dc_reg > knng_pkg::DC_W'(knng_pkg::MAX_DIMS))
                 ? knng_pkg::DC_W'(knng_pkg::MAX_DIMS) : dc_reg;
    assign k_eff = (nc_reg == '0) ? knng_pkg::NC_W'(1) : nc_reg;
    assign q_empty = ({1'b0, in_pi} >= n_eff) || (n_eff < knng_pkg::PC_W'(2));

    // query registers
    logic [knng_pkg::PIDX_W-1:0] pi_reg;
    logic [knng_pkg::PC_W-1:0]   n_reg;
    logic [knng_pkg::DIDX_W-1:0] dlast_reg;
    logic                        dzero_reg;
    logic [knng_pkg::NC_W-1:0]   k_reg;
    logic [knng_pkg::PIDX_W-1:0] j_reg;
    logic [knng_pkg::DIDX_W-1:0] l_reg;
    logic                        l_last;
    logic                        j_last;

    assign l_last = (l_reg == dlast_reg);
    assign j_last = ({1'b0, j_reg} == (n_reg - knng_pkg::PC_W'(1)));

    // point store
    logic [knng_pkg::COORD_BITS-1:0] rd_a;
    logic [knng_pkg::COORD_BITS-1:0] rd_b;
    logic                            st_we;

    assign st_we = s_fire && (s_tuser == knng_pkg::CMD_LOAD);

    knng_store u_store (
        .aclk    (aclk),
        .we      (st_we),
        .waddr   ({in_pi, in_di}),
        .wdata   (in_coord),
        .raddr_a ({pi_reg, l_reg}),
        .raddr_b ({j_reg, l_reg}),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // distance pipeline: read, difference, square, accumulate
    logic                                t1_vld_reg, t2_vld_reg, t3_vld_reg, done_vld_reg;
    logic                                t1_first_reg, t2_first_reg, t3_first_reg;
    logic                                t1_last_reg, t2_last_reg, t3_last_reg;
    logic [knng_pkg::PIDX_W-1:0]         t1_j_reg, t2_j_reg, t3_j_reg, done_j_reg;
    logic signed [knng_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [knng_pkg::SQ_W-1:0]    prod;
    logic [knng_pkg::SQ_W-1:0]           sq_reg;
    logic [knng_pkg::DIST_W-1:0]         acc_reg;
    logic                                walking;
    logic                                dup_hit;
    logic                                ins_go;
    logic                                pipe_empty;

    assign walking    = (state_reg == ST_WALK) || (state_reg == ST_DRAIN);
    assign dup_hit    = walking && done_vld_reg && (done_j_reg < pi_reg) && (acc_reg == '0);
    assign ins_go     = walking && done_vld_reg && (done_j_reg != pi_reg) && !dup_hit;
    assign pipe_empty = !t1_vld_reg && !t2_vld_reg && !t3_vld_reg && !done_vld_reg;
    assign prod       = diff_reg * diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || dup_hit) begin
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            t3_vld_reg   <= 1'b0;
            done_vld_reg <= 1'b0;
        end else begin
            t1_vld_reg   <= (state_reg == ST_WALK);
            t2_vld_reg   <= t1_vld_reg;
            t3_vld_reg   <= t2_vld_reg;
            done_vld_reg <= t3_vld_reg && t3_last_reg;
        end
        t1_first_reg <= (l_reg == '0);
        t1_last_reg  <= l_last;
        t1_j_reg     <= j_reg;
        t2_first_reg <= t1_first_reg;
        t2_last_reg  <= t1_last_reg;
        t2_j_reg     <= t1_j_reg;
        t3_first_reg <= t2_first_reg;
        t3_last_reg  <= t2_last_reg;
        t3_j_reg     <= t2_j_reg;
        done_j_reg   <= t3_j_reg;
        diff_reg     <= dzero_reg ? '0
                      : ($signed({rd_a[knng_pkg::COORD_BITS-1], rd_a})
                       - $signed({rd_b[knng_pkg::COORD_BITS-1], rd_b}));
        sq_reg       <= unsigned'(prod);
        if (t3_vld_reg) begin
            acc_reg <= (t3_first_reg ? '0 : acc_reg) + knng_pkg::DIST_W'(sq_reg);
        end
    end

    // neighbor chain
    knng_pkg::cell_ctrl_t chain_ctrl;
    knng_pkg::item_t      new_item;
    knng_pkg::item_t      head;
    knng_pkg::item_t      second;
    knng_pkg::item_t      tail;
    logic                 m_free;
    logic                 emit_fire;

    assign m_free    = !m_tvalid || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && m_free;
    assign new_item  = '{valid: 1'b1, sq_dist: acc_reg, idx: done_j_reg};

    always_comb begin
        chain_ctrl.clear  = s_fire && (s_tuser == knng_pkg::CMD_QUERY);
        chain_ctrl.insert = ins_go;
        chain_ctrl.rotate = (state_reg == ST_ROT) || emit_fire;
    end

    knng_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (chain_ctrl),
        .new_item (new_item),
        .head     (head),
        .second   (second),
        .tail     (tail)
    );

    // cut distance, overflow and emission bookkeeping
    logic [knng_pkg::DIST_W-1:0] thr_reg;
    logic                        ovf_reg;
    logic [knng_pkg::NC_W-1:0]   s_reg;
    logic [knng_pkg::NC_W-1:0]   r_reg;
    logic [knng_pkg::NC_W-1:0]   r_inc;
    logic                        next_ok;
    logic                        emit_last;
    logic [knng_pkg::PIDX_W-1:0] one_idx_reg;
    logic                        one_dup_reg;
    logic                        one_empty_reg;

    assign r_inc     = r_reg + knng_pkg::NC_W'(1);
    assign next_ok   = second.valid && ((r_inc < k_reg) || (second.sq_dist == thr_reg));
    assign emit_last = (r_reg == knng_pkg::NC_W'(knng_pkg::MAX_NEIGHBORS - 1)) || !next_ok;

    // result register
    logic                        m_valid_reg;
    logic [knng_pkg::PIDX_W-1:0] m_idx_reg;
    logic [knng_pkg::DIST_W-1:0] m_dist_reg;
    logic                        m_dup_reg;
    logic                        m_ovf_reg;
    logic                        m_empty_reg;
    logic                        m_last_reg;

    // control sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_tuser == knng_pkg::CMD_QUERY)) begin
                        pi_reg    <= in_pi;
                        n_reg     <= n_eff;
                        k_reg     <= k_eff;
                        dzero_reg <= (d_eff == '0);
                        dlast_reg <= (d_eff == '0) ? '0
                                   : knng_pkg::DIDX_W'(d_eff - knng_pkg::DC_W'(1));
                        j_reg     <= '0;
                        l_reg     <= '0;
                        if (q_empty) begin
                            one_idx_reg   <= '0;
                            one_dup_reg   <= 1'b0;
                            one_empty_reg <= 1'b1;
                            state_reg     <= ST_ONE;
                        end else begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK, ST_DRAIN: begin
                    if (state_reg == ST_WALK) begin
                        if (l_last) begin
                            l_reg <= '0;
                            j_reg <= j_reg + knng_pkg::PIDX_W'(1);
                            if (j_last) begin
                                state_reg <= ST_DRAIN;
                            end
                        end else begin
                            l_reg <= l_reg + knng_pkg::DIDX_W'(1);
                        end
                    end else if (pipe_empty) begin
                        s_reg     <= '0;
                        state_reg <= ST_ROT;
                    end
                    // an earlier copy ends the walk at once
                    if (dup_hit) begin
                        one_idx_reg   <= done_j_reg;
                        one_dup_reg   <= 1'b1;
                        one_empty_reg <= 1'b0;
                        state_reg     <= ST_ONE;
                    end
                end
                ST_ROT: begin
                    if (s_reg == k_reg - knng_pkg::NC_W'(1)) begin
                        thr_reg <= head.sq_dist;
                    end
                    s_reg <= s_reg + knng_pkg::NC_W'(1);
                    if (s_reg == knng_pkg::NC_W'(knng_pkg::CHAIN_LEN - 1)) begin
                        state_reg <= ST_FLAG;
                    end
                end
                ST_FLAG: begin
                    ovf_reg   <= tail.valid
                              && ((k_reg > knng_pkg::NC_W'(knng_pkg::MAX_NEIGHBORS))
                               || (tail.sq_dist == thr_reg));
                    r_reg     <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_free) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= head.idx;
                        m_dist_reg  <= head.sq_dist;
                        m_dup_reg   <= 1'b0;
                        m_ovf_reg   <= ovf_reg;
                        m_empty_reg <= 1'b0;
                        m_last_reg  <= emit_last;
                        r_reg       <= r_inc;
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_ONE: begin
                    if (m_free) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= one_idx_reg;
                        m_dist_reg  <= '0;
                        m_dup_reg   <= one_dup_reg;
                        m_ovf_reg   <= 1'b0;
                        m_empty_reg <= one_empty_reg;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output ports
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_dist_reg, m_idx_reg};
    assign m_tuser  = {m_empty_reg, m_ovf_reg, m_dup_reg};
    assign m_tlast  = m_last_reg;
endmodule
`default_nettype wire

/* hdl/knng_checker.sv */
// port-level checks of the k-nearest-neighbor graph block, bound to the top level
`default_nettype none
module knng_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [knng_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [knng_pkg::M_TUSER_W-1:0]    m_tuser,
    input wire logic                              m_tlast
);
    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an empty answer is a single closing transaction with no distance
    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast && (m_tdata[43:8] == '0) && !m_tuser[0])
        else $error("empty answer malformed");

    // a duplicate edge closes its query with zero weight
    a_dup_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata[43:8] == '0) && !m_tuser[1])
        else $error("duplicate edge malformed");
endmodule

bind knn_graph_from_points_core knng_checker u_knng_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
